// ===== rtl/core/lsq_pkg.sv =====
// Package for the least-squares slope block: field widths, transaction types,
// controller states and the command and status groups between the two halves.
// No dependencies.
`default_nettype none

package lsq_pkg;

    // Series limits and field widths.
    localparam int MAX_SAMPLES = 16384;
    localparam int SAMPLE_W    = 32;
    localparam int SLOPE_W     = 48;
    localparam int CNT_W       = 15;
    localparam int VSUM_W      = 46;
    localparam int WSUM_W      = 61;
    localparam int PROD_W      = 48;
    localparam int MULV_W      = 62;
    localparam int NUM_W       = 64;
    localparam int PAIR_W      = 30;
    localparam int PDEN_W      = 46;
    localparam int DEN_W       = 40;

    // Restoring divider for the slope: one quotient bit per step.
    localparam int DIV_STEPS   = NUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Reciprocal of three scaled by 2^RECIP_W; exact floor(x/3) for x below 2^16.
    localparam int               RECIP_W = 17;
    localparam logic [RECIP_W-1:0] RECIP3 = 17'h0AAAB;

    // Saturation limits for the slope magnitude.
    localparam logic [NUM_W-1:0] SLOPE_POS_MAX = NUM_W'(64'h0000_7FFF_FFFF_FFFF);
    localparam logic [NUM_W-1:0] SLOPE_NEG_MAG = NUM_W'(64'h0000_8000_0000_0000);

    // One input transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic                      too_few;
        logic                      overflowed;
    } result_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FORM,
        ST_DEN_LOAD,
        ST_NUM_LOAD,
        ST_NUM_DIV,
        ST_ROUND,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mac;
        logic prep;
        logic form;
        logic den_load;
        logic num_load;
        logic div_step;
        logic round;
        logic load_out;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic few;
        logic div_last;
        logic out_free;
    } status_t;

endpackage : lsq_pkg

`default_nettype wire

// ===== rtl/core/lsq_ctrl.sv =====
// Controller for the least-squares slope block: sequences accumulation,
// numerator and denominator formation, the division and the result.
// Depends on lsq_pkg.
`default_nettype none

module lsq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           item_last,
    input  wire lsq_pkg::status_t status,
    output lsq_pkg::cmd_t       cmd,
    output logic                item_ready
);

    lsq_pkg::state_t state_reg;
    lsq_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsq_pkg::ST_IDLE:
            begin
                if (item_valid && item_last)
                begin
                    state_next = lsq_pkg::ST_PREP;
                end
            end
            lsq_pkg::ST_PREP:
            begin
                state_next = status.few ? lsq_pkg::ST_EMIT : lsq_pkg::ST_FORM;
            end
            lsq_pkg::ST_FORM:     state_next = lsq_pkg::ST_DEN_LOAD;
            lsq_pkg::ST_DEN_LOAD: state_next = lsq_pkg::ST_NUM_LOAD;
            lsq_pkg::ST_NUM_LOAD: state_next = lsq_pkg::ST_NUM_DIV;
            lsq_pkg::ST_NUM_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = lsq_pkg::ST_ROUND;
                end
            end
            lsq_pkg::ST_ROUND:    state_next = lsq_pkg::ST_EMIT;
            lsq_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = lsq_pkg::ST_IDLE;
                end
            end
            default:              state_next = lsq_pkg::ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            lsq_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.mac    = item_valid;
            end
            lsq_pkg::ST_PREP:     cmd.prep     = 1'b1;
            lsq_pkg::ST_FORM:     cmd.form     = 1'b1;
            lsq_pkg::ST_DEN_LOAD: cmd.den_load = 1'b1;
            lsq_pkg::ST_NUM_LOAD: cmd.num_load = 1'b1;
            lsq_pkg::ST_NUM_DIV:  cmd.div_step = 1'b1;
            lsq_pkg::ST_ROUND:    cmd.round    = 1'b1;
            lsq_pkg::ST_EMIT:
            begin
                cmd.load_out = status.out_free;
                cmd.clear    = status.out_free;
            end
            default:
            begin
                cmd        = '0;
                item_ready = 1'b0;
            end
        endcase
    end

endmodule : lsq_ctrl

`default_nettype wire

// ===== rtl/core/lsq_dpath.sv =====
// Datapath for the least-squares slope block: accumulators, numerator and
// denominator products, a restoring divider and the result register.
// Depends on lsq_pkg.
`default_nettype none

module lsq_dpath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsq_pkg::cmd_t   cmd,
    input  wire lsq_pkg::item_t  item,
    input  wire logic            result_ready,
    output lsq_pkg::status_t     status,
    output logic                 result_valid,
    output lsq_pkg::result_t     result
);

    // Series state.
    logic        [lsq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic signed [lsq_pkg::VSUM_W-1:0] vsum_reg, vsum_next;
    logic signed [lsq_pkg::WSUM_W-1:0] wsum_reg, wsum_next;
    logic                              drop_reg, drop_next;

    // Intermediate products.
    logic signed [lsq_pkg::MULV_W-1:0] mulv_reg;
    logic        [lsq_pkg::CNT_W-1:0]  third_reg;
    logic        [lsq_pkg::PAIR_W-1:0] pair_reg;
    logic        [lsq_pkg::NUM_W-1:0]  mag_reg;
    logic                              neg_reg;

    // Divider.
    logic [lsq_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [lsq_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [lsq_pkg::DEN_W-1:0]  dvs_reg;
    logic [lsq_pkg::STEP_W-1:0] step_reg, step_next;

    // Result holding and output registers.
    lsq_pkg::result_t res_reg;
    lsq_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;

    logic signed [lsq_pkg::PROD_W-1:0] mac_prod;
    logic        [lsq_pkg::CNT_W-1:0]  nm1;
    logic        [lsq_pkg::CNT_W:0]    np1;
    logic        [lsq_pkg::CNT_W+lsq_pkg::RECIP_W:0] recip_prod;
    logic        [1:0]                 rem3;
    logic        [lsq_pkg::CNT_W:0]    fac_a;
    logic        [lsq_pkg::CNT_W-1:0]  fac_b;
    logic        [lsq_pkg::PDEN_W-1:0] pden;
    logic signed [lsq_pkg::NUM_W-1:0]  num;
    logic        [lsq_pkg::DEN_W+1:0]  trial;
    logic        [lsq_pkg::DEN_W:0]    rem_dbl;
    logic        [lsq_pkg::NUM_W-1:0]  q_round;
    logic                              sat;
    logic        [lsq_pkg::NUM_W-1:0]  q_sat;
    logic        [lsq_pkg::NUM_W-1:0]  q_signed;

    // Multiply-accumulate of one sample against its index.
    assign mac_prod = $signed({1'b0, count_reg}) * item.sample;

    always_comb
    begin
        count_next = count_reg;
        vsum_next  = vsum_reg;
        wsum_next  = wsum_reg;
        drop_next  = drop_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            vsum_next  = '0;
            wsum_next  = '0;
            drop_next  = 1'b0;
        end
        else if (cmd.mac)
        begin
            if (count_reg < lsq_pkg::CNT_W'(lsq_pkg::MAX_SAMPLES))
            begin
                count_next = count_reg + lsq_pkg::CNT_W'(1);
                vsum_next  = vsum_reg + {{(lsq_pkg::VSUM_W - lsq_pkg::SAMPLE_W)
                                          {item.sample[lsq_pkg::SAMPLE_W-1]}}, item.sample};
                wsum_next  = wsum_reg + {{(lsq_pkg::WSUM_W - lsq_pkg::PROD_W)
                                          {mac_prod[lsq_pkg::PROD_W-1]}}, mac_prod};
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            vsum_reg  <= '0;
            wsum_reg  <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            vsum_reg  <= vsum_next;
            wsum_reg  <= wsum_next;
            drop_reg  <= drop_next;
        end
    end

    // Numerator 2*sum_iy - (n-1)*sum_y and its sign and magnitude.
    assign nm1 = count_reg - lsq_pkg::CNT_W'(1);
    assign np1 = {1'b0, count_reg} + (lsq_pkg::CNT_W + 1)'(1);
    assign num = {{(lsq_pkg::NUM_W - lsq_pkg::WSUM_W - 1){wsum_reg[lsq_pkg::WSUM_W-1]}},
                  wsum_reg, 1'b0}
               - {{(lsq_pkg::NUM_W - lsq_pkg::MULV_W){mulv_reg[lsq_pkg::MULV_W-1]}}, mulv_reg};

    // Denominator n*(n-1)*(n+1)/6 without a divider. The quotient floor((n+1)/3),
    // taken by reciprocal multiplication, is exactly a third of whichever of
    // n-1, n and n+1 is a multiple of three; the remainder of n+1 picks that
    // factor, the other two form a pair, and the final halving is a shift.
    assign recip_prod = (lsq_pkg::CNT_W + lsq_pkg::RECIP_W + 1)'(np1)
                      * (lsq_pkg::CNT_W + lsq_pkg::RECIP_W + 1)'(lsq_pkg::RECIP3);
    assign rem3  = np1[1:0] - {third_reg[0], 1'b0} - third_reg[1:0];
    assign fac_a = (rem3 == 2'd0) ? {1'b0, count_reg} : np1;
    assign fac_b = (rem3 == 2'd2) ? count_reg : nm1;
    assign pden  = lsq_pkg::PDEN_W'(third_reg) * lsq_pkg::PDEN_W'(pair_reg);

    // One restoring division step.
    assign trial = {1'b0, rem_reg, quo_reg[lsq_pkg::NUM_W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.num_load)
        begin
            quo_next  = mag_reg;
            rem_next  = '0;
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            step_next = step_reg + lsq_pkg::STEP_W'(1);
            if (!trial[lsq_pkg::DEN_W+1])
            begin
                rem_next = trial[lsq_pkg::DEN_W-1:0];
                quo_next = {quo_reg[lsq_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[lsq_pkg::DEN_W-2:0], quo_reg[lsq_pkg::NUM_W-1]};
                quo_next = {quo_reg[lsq_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Rounding to nearest with ties away from zero, then saturation.
    assign rem_dbl  = {rem_reg, 1'b0};
    assign q_round  = quo_reg + lsq_pkg::NUM_W'(rem_dbl >= {1'b0, dvs_reg});
    assign sat      = neg_reg ? (q_round > lsq_pkg::SLOPE_NEG_MAG)
                              : (q_round > lsq_pkg::SLOPE_POS_MAX);
    assign q_sat    = !sat ? q_round
                    : (neg_reg ? lsq_pkg::SLOPE_NEG_MAG : lsq_pkg::SLOPE_POS_MAX);
    assign q_signed = neg_reg ? (lsq_pkg::NUM_W'(0) - q_sat) : q_sat;

    // Payload registers of the final calculation.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            mulv_reg           <= $signed({1'b0, nm1}) * vsum_reg;
            third_reg          <= recip_prod[lsq_pkg::RECIP_W +: lsq_pkg::CNT_W];
            res_reg.slope      <= '0;
            res_reg.too_few    <= 1'b1;
            res_reg.overflowed <= drop_reg;
        end
        if (cmd.form)
        begin
            neg_reg  <= num[lsq_pkg::NUM_W-1];
            mag_reg  <= num[lsq_pkg::NUM_W-1] ? (lsq_pkg::NUM_W'(0) - num) : num;
            pair_reg <= lsq_pkg::PAIR_W'(fac_a) * lsq_pkg::PAIR_W'(fac_b);
        end
        if (cmd.den_load)
        begin
            dvs_reg <= pden[lsq_pkg::DEN_W:1];
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.round)
        begin
            res_reg.slope      <= q_signed[lsq_pkg::SLOPE_W-1:0];
            res_reg.too_few    <= 1'b0;
            res_reg.overflowed <= drop_reg | sat;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    // Output register: holds one result transaction until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Status back to the controller.
    assign status.few      = count_reg < lsq_pkg::CNT_W'(2);
    assign status.div_last = step_reg == lsq_pkg::STEP_W'(lsq_pkg::DIV_STEPS - 1);
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule : lsq_dpath

`default_nettype wire

// ===== rtl/core/least_squares_slope.sv =====
// Top level of the least-squares slope block: controller and datapath.
// Depends on lsq_pkg, lsq_ctrl and lsq_dpath.
//
// Samples (signed Q16.16) are accepted one per cycle while the series is being
// gathered; each costs one multiply-accumulate of the sample against its index.
// Up to 16384 samples are kept, later ones are dropped and reported through
// overflowed. The transaction marked last closes the series: the block then
// stops accepting samples while it forms the numerator and denominator,
// runs the one-bit-per-cycle divider for the 64 steps of the slope, rounds
// it and moves it into the output register. A series of fewer than two
// samples gives slope zero with too_few set. In either case the move waits
// while a previous result still waits untaken in the output register. The
// next series may start as soon as the result is in the output register,
// even before it is taken.
`default_nettype none

module least_squares_slope (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire lsq_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output lsq_pkg::result_t      result
);

    lsq_pkg::cmd_t    cmd;
    lsq_pkg::status_t status;

    // Sequencing.
    lsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last),
        .status     (status),
        .cmd        (cmd),
        .item_ready (item_ready)
    );

    // Arithmetic and storage.
    lsq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_ready (result_ready),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    // At most one datapath operation other than clear is commanded in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mac, cmd.prep, cmd.form, cmd.den_load, cmd.num_load,
                  cmd.div_step, cmd.round, cmd.load_out}))
        else $error("several datapath commands in one cycle");

    // No sample is taken while a result is moved into the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !item_ready)
        else $error("sample accepted while loading a result");

    // A short series always reports a zero slope.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.too_few) |-> (result.slope == '0))
        else $error("too_few result with non-zero slope");

    // A new result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !cmd.load_out)
        else $error("result overwritten before it was taken");

endmodule : least_squares_slope

`default_nettype wire
